// ===== rtl/sha256_byte_stream_hash_top_assert.svh =====
// Assertion macros for the SHA-256 byte stream hash block.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef SHA256_BYTE_STREAM_HASH_TOP_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_TOP_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define SHABS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define SHABS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/shabs_pkg.sv =====
// Package for the SHA-256 byte stream hash: sequencer states, round control,
// round constants, initial hash values and the rotate/sigma functions.
`timescale 1ns / 1ps

package shabs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_OUT
	} shabs_state_t;

	typedef struct packed {
		logic restart;
		logic load;
		logic step;
		logic update;
	} shabs_ctrl_t;

	localparam logic [7:0] MARK_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_POS  = 6'd63;
	localparam logic [5:0] LAST_RND  = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// message schedule sigmas
	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// round sigmas
	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== rtl/shabs_round.sv =====
// Shared SHA-256 round unit: working variables, hash state and final add.
// Depends on shabs_pkg for constants, sigmas and the control struct.
`timescale 1ns / 1ps

module shabs_round import shabs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  shabs_ctrl_t ctrl,
	input  logic [5:0]  rnd,
	input  logic [31:0] w,
	input  logic [2:0]  rd_idx,
	output logic [31:0] rd_word
);

	logic [31:0] hash_q [8];
	logic [31:0] var_q  [8];
	logic [31:0] ch, maj, t1, t2;

	always_comb begin
		ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1  = var_q[7] + bsig1(var_q[4]) + ch + ROUND_K[rnd] + w;
		t2  = bsig0(var_q[0]) + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= INIT_H;
		end else if (ctrl.restart) begin
			hash_q <= INIT_H;
		end else if (ctrl.update) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + var_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= '0;
			end
		end else if (ctrl.load) begin
			var_q <= hash_q;
		end else if (ctrl.step) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	assign rd_word = hash_q[rd_idx];

endmodule

// ===== rtl/sha256_byte_stream_hash_top.sv =====
// SHA-256 over a byte stream: one message byte per request, digest out as
// eight 32-bit words. Depends on shabs_pkg, shabs_round and the assert header.
`timescale 1ns / 1ps

// One request carries at most one message byte; end_of_message closes the
// message and may come with no byte (empty message allowed). Bytes shift into
// a 64-byte window register one per cycle while the input is ready; a full
// block goes through a load step, 64 rounds of the single shared round unit
// and an update step that folds the result into the hash state. The input is
// not ready while a block is padded or compressed or the digest is offered.
// Finishing a message writes the padding one byte per cycle (0x80, zeros and
// the 64-bit bit length) into the same window, adding one or two blocks. The
// wait from the end of the message to the first digest word is longest when
// 0x80 lands on byte 56: that block is padded out and compressed, then a full
// padding block with the length follows. The digest is then offered as eight
// results, word 0 (most significant) first. len_overflow is set on all eight
// words when the message ran past 2^61-1 bytes; the digest is still computed
// over the length taken modulo 2^64 bits. After word 7 is taken the hash state,
// byte count and error flag return to their initial values. No clearing pass
// after reset is needed.
module sha256_byte_stream_hash_top import shabs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        final_word,
	output logic        len_overflow
);

`include "sha256_byte_stream_hash_top_assert.svh"

	shabs_state_t state_q, state_d;

	// 64-byte window: block buffer while filling, schedule line while compressing
	logic [511:0] win_q;
	logic [5:0]   fill_q;
	logic [60:0]  byte_count_q;
	logic         too_long_q;
	logic [5:0]   rnd_q;
	logic [2:0]   word_q;

	// padding progress
	logic pad_q;     // end of message seen
	logic mark_q;    // 0x80 written
	logic len_ok_q;  // length field fits in the current block
	logic final_q;   // current block carries the length

	logic        accept_in;
	logic        take_byte;
	logic        out_done;
	logic [7:0]  pad_byte;
	logic [63:0] len_bits;
	logic [5:0]  len_shift;
	logic [31:0] w_cur, w_next;
	shabs_ctrl_t ctrl;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept_in = in_valid && in_ready;
	assign take_byte = accept_in && byte_present;
	assign out_done  = (state_q == ST_OUT) && out_ready && (word_q == LAST_WORD);

	// length field, big-endian, byte fill_q[2:0] of 8
	assign len_bits  = {byte_count_q, 3'b000};
	assign len_shift = {~fill_q[2:0], 3'b000};

	always_comb begin
		if (!mark_q) begin
			pad_byte = MARK_BYTE;
		end else if (len_ok_q && (fill_q >= LEN_POS)) begin
			pad_byte = 8'(len_bits >> len_shift);
		end else begin
			pad_byte = '0;
		end
	end

	// window holds w[i..i+15] in round i; w[i+16] enters at the tail
	assign w_cur  = win_q[511:480];
	assign w_next = win_q[511:480] + ssig0(win_q[479:448]) + win_q[223:192]
		+ ssig1(win_q[63:32]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_byte && (fill_q == LAST_POS)) begin
					state_d = ST_LOAD;
				end else if (accept_in && end_of_message) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (fill_q == LAST_POS) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == LAST_RND) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (final_q) begin
					state_d = ST_OUT;
				end else if (pad_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (out_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte) begin
			win_q <= {win_q[503:0], data_byte};
		end else if (state_q == ST_PAD) begin
			win_q <= {win_q[503:0], pad_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], w_next};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			byte_count_q <= '0;
			too_long_q   <= 1'b0;
			rnd_q        <= '0;
			word_q       <= '0;
			pad_q        <= 1'b0;
			mark_q       <= 1'b0;
			len_ok_q     <= 1'b0;
			final_q      <= 1'b0;
		end else begin
			if (take_byte || (state_q == ST_PAD)) begin
				fill_q <= fill_q + 6'd1;
			end
			if (take_byte) begin
				byte_count_q <= byte_count_q + 61'd1;
				if (&byte_count_q) begin
					too_long_q <= 1'b1;
				end
			end
			if (accept_in && end_of_message) begin
				pad_q <= 1'b1;
			end
			if (state_q == ST_PAD) begin
				if (!mark_q) begin
					mark_q <= 1'b1;
					if (fill_q < LEN_POS) begin
						len_ok_q <= 1'b1;
					end
				end else if (len_ok_q && (fill_q == LAST_POS)) begin
					final_q <= 1'b1;
				end
			end
			// a padding block without the length: the next one has room
			if ((state_q == ST_UPDATE) && pad_q && !final_q) begin
				len_ok_q <= 1'b1;
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if ((state_q == ST_OUT) && out_ready) begin
				word_q <= word_q + 3'd1;
			end
			if (out_done) begin
				byte_count_q <= '0;
				too_long_q   <= 1'b0;
				pad_q        <= 1'b0;
				mark_q       <= 1'b0;
				len_ok_q     <= 1'b0;
				final_q      <= 1'b0;
			end
		end
	end

	always_comb begin
		ctrl.restart = out_done;
		ctrl.load    = (state_q == ST_LOAD);
		ctrl.step    = (state_q == ST_ROUND);
		ctrl.update  = (state_q == ST_UPDATE);
	end

	shabs_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rnd     (rnd_q),
		.w       (w_cur),
		.rd_idx  (word_q),
		.rd_word (digest_word)
	);

	assign out_valid    = (state_q == ST_OUT);
	assign word_number  = word_q;
	assign final_word   = (word_q == LAST_WORD);
	assign len_overflow = too_long_q;

	// input and output sides are never open together
	`SHABS_ASSERT(a_ready_excl, !(in_ready && out_valid), "input ready while digest pending")
	// a block always starts compressing from an empty window position
	`SHABS_ASSERT(a_load_fill, (state_q != ST_LOAD) || (fill_q == '0), "load with partial block")
	// 64 rounds, then the hash state update
	`SHABS_ASSERT_NEXT(a_round_end, (state_q == ST_ROUND) && (rnd_q == LAST_RND), state_q == ST_UPDATE, "round count overran")
	// digest always starts at word 0
	`SHABS_ASSERT(a_out_first, !$rose(out_valid) || (word_q == '0), "digest not started at word 0")
	// the length block only appears after the end marker
	`SHABS_ASSERT(a_final_pad, !final_q || (pad_q && mark_q && len_ok_q), "length block without padding")

endmodule

// ===== test/sha256_byte_stream_hash_top_tb.sv =====
// Self-checking testbench for sha256_byte_stream_hash_top: byte stream in, eight digest
// words out, predicted by an in-bench SHA-256 model. Depends on the RTL top module only.
`timescale 1ns / 1ps

module sha256_byte_stream_hash_top_tb;

	localparam int IDLE_PCT    = 27;     // idle chance per cycle on each side
	localparam int HOLD_CYCLES = 1500;   // long receiver hold-off
	localparam int ITEM_GOAL   = 300;    // message requests to send (empty items excluded)
	localparam int DRAIN_WAIT  = 400;    // > one padded block plus output after last word

	// round constants and initial chaining value (FIPS 180-4)
	localparam logic [31:0] K_TABLE [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] IV_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam int         LEN_SLOT = 56;   // first byte of the bit-length field

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
		logic        err;
	} digest_entry_t;

	// DUT signals; everything driven by the bench starts at a known value
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        final_word;
	logic        len_overflow;

	// bench control
	logic steady = 1'b0;     // 1: neither side idles
	int   hold_asks = 0;     // bumped by a test to request a receiver hold-off
	int   hold_seen = 0;
	int   hold_left = 0;
	int   sent_items = 0;
	int   errors = 0;

	// predictor state
	logic [31:0]   chain_value [8];
	logic [7:0]    msg_block [64];
	logic [60:0]   msg_bytes;
	logic          too_long;
	digest_entry_t expected_words [$];

	sha256_byte_stream_hash_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digest_word    (digest_word),
		.word_number    (word_number),
		.final_word     (final_word),
		.len_overflow   (len_overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor: SHA-256 over the accepted bytes
	// ------------------------------------------------------------------
	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one compression of msg_block into chain_value, rolling 16-word schedule
	function automatic void fold_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] t1, t2, x15, x2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 0; i < 8; i++)
			v[i] = chain_value[i];
		for (int r = 0; r < 64; r++) begin
			if (r >= 16) begin
				x15 = w[(r - 15) % 16];
				x2  = w[(r - 2) % 16];
				w[r % 16] = w[r % 16] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
					+ w[(r - 7) % 16] + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[r] + w[r % 16];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_value[i] = chain_value[i] + v[i];
	endfunction

	function automatic void restart_digest();
		for (int i = 0; i < 8; i++)
			chain_value[i] = IV_WORDS[i];
		msg_bytes = '0;
		too_long = 1'b0;
	endfunction

	// fold one accepted request into the running hash; on end of message pad,
	// finish and queue the eight digest words
	function automatic void absorb_request(input logic [7:0] b, input logic p, input logic e);
		logic [63:0]   bit_len;
		int            pos;
		digest_entry_t entry;
		if (p) begin
			msg_block[msg_bytes[5:0]] = b;
			msg_bytes = msg_bytes + 61'd1;
			if (msg_bytes == '0)
				too_long = 1'b1;    // count wrapped past 2^61-1
			if (msg_bytes[5:0] == 6'd0)
				fold_block();
		end
		if (!e)
			return;
		pos = int'(msg_bytes[5:0]);
		msg_block[pos] = PAD_MARK;
		pos = pos + 1;
		if (pos > LEN_SLOT) begin
			// no room for the length: pad out and spend an extra block
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos = pos + 1;
			end
			fold_block();
			pos = 0;
		end
		while (pos < LEN_SLOT) begin
			msg_block[pos] = 8'h00;
			pos = pos + 1;
		end
		bit_len = {msg_bytes, 3'b000};
		for (int i = 0; i < 8; i++)
			msg_block[LEN_SLOT + i] = bit_len[63 - 8*i -: 8];
		fold_block();
		for (int i = 0; i < 8; i++) begin
			entry.word  = chain_value[i];
			entry.index = 3'(i);
			entry.last  = (i == 7);
			entry.err   = too_long;
			expected_words = {expected_words, entry};
		end
		restart_digest();
	endfunction

	initial restart_digest();

	// predict on every accepted request
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			absorb_request(data_byte, byte_present, end_of_message);
	end

	// ------------------------------------------------------------------
	// Receiver: random idling, long hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ------------------------------------------------------------------
	// Checker: each accepted word against the oldest expected one
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_digest
		digest_entry_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				errors++;
				$error("unexpected digest word %h (word_number %0d)", digest_word, word_number);
			end else begin
				want = expected_words.pop_front();
				if (digest_word !== want.word) begin
					errors++;
					$error("digest_word: expected %h, got %h", want.word, digest_word);
				end
				if (word_number !== want.index) begin
					errors++;
					$error("word_number: expected %0d, got %0d", want.index, word_number);
				end
				if (final_word !== want.last) begin
					errors++;
					$error("final_word: expected %b, got %b", want.last, final_word);
				end
				if (len_overflow !== want.err) begin
					errors++;
					$error("len_overflow: expected %b, got %b", want.err, len_overflow);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	// Offer one request and return in the step it is accepted. valid is left
	// high so a following request goes out back to back.
	task automatic send_request(input logic [7:0] b, input logic p, input logic e);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		byte_present   <= p;
		end_of_message <= e;
		do @(posedge clk); while (!in_ready);
		if (p || e)
			sent_items++;
	endtask

	// message of len random bytes, with stray empty items; the end marker
	// either rides on the last byte or comes as a byte-less request
	task automatic send_message(input int len);
		bit split_end;
		split_end = (len == 0) || ($urandom_range(99) < 30);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				send_request(8'($urandom_range(255)), 1'b0, 1'b0);
			send_request(8'($urandom_range(255)), 1'b1, !split_end && (i == len - 1));
		end
		if (split_end)
			send_request(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// sender pause: nothing offered until every digest word is back
	task automatic wait_for_digests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// empty message, twice in a row; data_byte is ignored
	task automatic test_empty_messages();
		send_request(8'hff, 1'b0, 1'b1);
		send_request(8'h00, 1'b0, 1'b1);
		wait_for_digests();
	endtask

	// short known messages, byte extremes, empty items, both end styles
	task automatic test_short_messages();
		send_request(8'h61, 1'b1, 1'b0);                   // "abc"
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b1);                   // single zero byte
		send_request(8'h5a, 1'b0, 1'b0);                   // empty item at message start
		send_request(8'hff, 1'b1, 1'b0);
		send_request(8'ha5, 1'b0, 1'b0);                   // empty item mid message
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hff, 1'b0, 1'b1);                   // end without a byte
		send_request(8'h80, 1'b1, 1'b0);
		send_request(8'h7f, 1'b1, 1'b1);
		wait_for_digests();
	endtask

	// lengths around the length-field slot and a full block: 55 fits one pad
	// block, 56 needs two, 64 ends on a block edge. The first two go with no
	// idling on either side.
	task automatic test_padding_edges();
		steady <= 1'b1;
		send_message(55);
		send_message(56);
		wait_for_digests();
		steady <= 1'b0;
		send_message(64);
		wait_for_digests();
	endtask

	// receiver holds off while the sender keeps offering: the first digest
	// blocks the output and the input must stall behind it
	task automatic test_output_backpressure();
		hold_asks <= hold_asks + 1;
		for (int m = 0; m < 4; m++)
			send_message(3);
		wait_for_digests();
	endtask

	// mostly short messages, some across one or two block edges
	task automatic test_random_messages();
		while (sent_items < ITEM_GOAL) begin
			if ($urandom_range(99) < 80)
				send_message($urandom_range(12));
			else
				send_message($urandom_range(70, 50));
		end
		wait_for_digests();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_messages();
		test_short_messages();
		test_padding_edges();
		test_output_backpressure();
		test_random_messages();
		// catch any stray word after the last digest
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit, far above the slowest passing run
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
